// ----- design/fir_pkg.sv -----
package fir_pkg;

  localparam int TAPS       = 32;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int COEF_IDX_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int FRAC_BITS  = 15;

  localparam int TAP_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int ACC_W  = PROD_W + TAP_W + 1;
  localparam int Q_W    = ACC_W - FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_INDEX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_VALUE = 2'd1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } mac_ctrl_t;

endpackage

// ----- design/fir_taps.sv -----
module fir_taps
  import fir_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             shift_en,
  input  sample_t          shift_sample,
  input  logic             wr_en,
  input  logic [TAP_W-1:0] wr_addr,
  input  coef_t            wr_data,
  input  logic [TAP_W-1:0] rd_addr,
  output sample_t          rd_sample,
  output coef_t            rd_coef
);

  sample_t delay [TAPS];
  coef_t   coefs [TAPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TAPS; k++) begin
        delay[k] <= '0;
      end
    end else if (shift_en) begin
      for (int k = TAPS - 1; k > 0; k--) begin
        delay[k] <= delay[k-1];
      end
      delay[0] <= shift_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TAPS; k++) begin
        coefs[k] <= '0;
      end
    end else if (wr_en) begin
      coefs[wr_addr] <= wr_data;
    end
  end

  assign rd_sample = delay[rd_addr];
  assign rd_coef   = coefs[rd_addr];

endmodule

// ----- design/fir_mac.sv -----
module fir_mac
  import fir_pkg::*;
(
  input  logic      clk,
  input  mac_ctrl_t ctrl,
  input  sample_t   sample,
  input  coef_t     coef,
  output sample_t   filtered,
  output logic      saturated
);

  localparam logic signed [Q_W-1:0]   Q_MAX    = Q_W'(2**(SAMPLE_W-1) - 1);
  localparam logic signed [Q_W-1:0]   Q_MIN    = -Q_W'(2**(SAMPLE_W-1));
  localparam logic signed [ACC_W-1:0] ROUND_IN = ACC_W'(2**FRAC_BITS - 1);

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_adj;
  logic signed [Q_W-1:0]    q;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= PROD_W'(sample) * PROD_W'(coef);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Biasing negative sums before the arithmetic shift gives truncation toward zero.
  assign acc_adj = acc + (acc[ACC_W-1] ? ROUND_IN : '0);
  assign q       = acc_adj[ACC_W-1:FRAC_BITS];

  always_comb begin
    if (q > Q_MAX) begin
      filtered  = sample_t'(Q_MAX);
      saturated = 1'b1;
    end else if (q < Q_MIN) begin
      filtered  = sample_t'(Q_MIN);
      saturated = 1'b1;
    end else begin
      filtered  = q[SAMPLE_W-1:0];
      saturated = 1'b0;
    end
  end

endmodule

// ----- design/fir_filter_mono.sv -----
// Direct-form FIR filter for one mono audio stream.
// Input channel: sample_valid / sample_stall carry sample_in; a transfer takes
// place on a clock edge with sample_valid high and sample_stall low.
// Output channel: result_valid / result_stall carry filtered_out and clipped,
// the latter set when the result was saturated to the 16-bit limits.
// Coefficients are loaded through the configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data): index 0 selects the table entry, index 1
// writes a Q1.15 coefficient there. The user must make writes only while no sample
// is in flight; the block itself does not enforce it. cfg_ready is always high.
// One shared multiplier and accumulator walk the taps, one tap per cycle.
// Each accepted sample passes through the RUN, DRAIN and DONE states before its
// result is loaded into the output register; sample_stall stays high until the block
// is back in IDLE, so a new sample is taken only after the last one is finished.
// If the receiver stalls, the finished result is held in the output register
// and the next sample can still be accepted and computed; it then waits until
// the output register is free.
// A synchronous reset clears the delay line, the coefficient table, the
// coefficient index and both channels.
module fir_filter_mono
  import fir_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  sample_t               sample_in,
  output logic                  result_valid,
  input  logic                  result_stall,
  output sample_t               filtered_out,
  output logic                  clipped,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(TAPS - 1);

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [TAP_W-1:0]      cnt;
  logic [COEF_IDX_W-1:0] coef_index;

  logic      accept;
  logic      cfg_write;
  logic      coef_wr;
  logic      load_out;
  mac_ctrl_t mac_ctrl;
  sample_t   tap_sample;
  coef_t     tap_coef;
  sample_t   mac_filtered;
  logic      mac_saturated;

  assign cfg_ready    = 1'b1;
  assign sample_stall = (state != S_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign cfg_write    = cfg_valid && cfg_ready;
  assign coef_wr      = cfg_write && (cfg_index == CFG_COEF_VALUE) &&
                        (32'(coef_index) < 32'(TAPS));
  assign load_out     = (state == S_DONE) && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_index <= '0;
    end else if (cfg_write && (cfg_index == CFG_COEF_INDEX)) begin
      coef_index <= cfg_data[COEF_IDX_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_RUN;
      end
      S_RUN: begin
        if (cnt == LAST_TAP) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (load_out) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_RUN) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  assign mac_ctrl.clear  = accept;
  assign mac_ctrl.mul_en = (state == S_RUN);
  assign mac_ctrl.acc_en = ((state == S_RUN) && (cnt != '0)) || (state == S_DRAIN);

  fir_taps u_taps (
    .clk          (clk),
    .rst          (rst),
    .shift_en     (accept),
    .shift_sample (sample_in),
    .wr_en        (coef_wr),
    .wr_addr      (TAP_W'(coef_index)),
    .wr_data      (coef_t'(cfg_data)),
    .rd_addr      (cnt),
    .rd_sample    (tap_sample),
    .rd_coef      (tap_coef)
  );

  fir_mac u_mac (
    .clk       (clk),
    .ctrl      (mac_ctrl),
    .sample    (tap_sample),
    .coef      (tap_coef),
    .filtered  (mac_filtered),
    .saturated (mac_saturated)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      filtered_out <= mac_filtered;
      clipped      <= mac_saturated;
    end
  end

endmodule

// ----- design/fir_chk.sv -----
module fir_chk
  import fir_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    sample_valid,
  input logic    sample_stall,
  input logic    result_valid,
  input logic    result_stall,
  input sample_t filtered_out,
  input logic    clipped
);

  localparam sample_t OUT_MAX = sample_t'(2**(SAMPLE_W-1) - 1);
  localparam sample_t OUT_MIN = -sample_t'(2**(SAMPLE_W-1));

  logic sample_xfer;

  assign sample_xfer = sample_valid && !sample_stall;

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    sample_xfer |=> sample_stall)
    else $error("sample accepted while a sample was still being filtered");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    sample_xfer |=> !$rose(result_valid))
    else $error("result appeared one cycle after its sample");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(filtered_out) && $stable(clipped))
    else $error("stalled result changed");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid && clipped |-> (filtered_out == OUT_MAX) || (filtered_out == OUT_MIN))
    else $error("clipped set on an unsaturated result");

endmodule

bind fir_filter_mono fir_chk u_fir_chk (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .filtered_out (filtered_out),
  .clipped      (clipped)
);

// ----- tb/sv/tb_fir_filter_mono.sv -----
module tb_fir_filter_mono;
  timeunit 1ns;
  timeprecision 1ps;

  import fir_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam longint OUT_MAX = 2**(SAMPLE_W-1) - 1;
  localparam longint OUT_MIN = -(2**(SAMPLE_W-1));
  localparam sample_t SAMPLE_HI = sample_t'(OUT_MAX);
  localparam sample_t SAMPLE_LO = sample_t'(OUT_MIN);
  localparam coef_t COEF_HI = coef_t'(OUT_MAX);
  localparam coef_t COEF_LO = coef_t'(OUT_MIN);
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_ITEMS = 610;
  localparam int SETTLE_CYCLES = TAPS + 8;

  typedef enum {TABLE_UNITY, TABLE_MIN, TABLE_MAX, TABLE_RANDOM, TABLE_MILD} table_kind_t;

  typedef struct {
    sample_t value;
    logic    clip;
  } filt_result_t;

  class fir_output_check;
    sample_t               history[TAPS];
    coef_t                 coefs[TAPS];
    logic [COEF_IDX_W-1:0] coef_sel;
    coef_t                 coef_reg;
    filt_result_t          pending[$];
    int                    fails;
    int                    reports;

    function new();
      foreach (history[k]) history[k] = '0;
      foreach (coefs[k]) coefs[k] = '0;
      coef_sel = '0;
      coef_reg = '0;
      fails = 0;
      reports = 0;
    endfunction

    function void note_fail(string msg);
      fails++;
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("%0t ns: %s", $time, msg);
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_COEF_INDEX: begin
          coef_sel = data[COEF_IDX_W-1:0];
        end
        CFG_COEF_VALUE: begin
          coef_reg = coef_t'(data);
          if (int'(coef_sel) < TAPS) coefs[coef_sel] = coef_reg;
        end
        default: begin
        end
      endcase
    endfunction

    // The new sample enters the delay line and the filtered output it causes is queued.
    function void take_sample(sample_t s);
      longint acc;
      longint q;
      filt_result_t r;
      for (int k = TAPS - 1; k > 0; k--) history[k] = history[k-1];
      history[0] = s;
      acc = 0;
      for (int k = 0; k < TAPS; k++) acc += longint'(history[k]) * longint'(coefs[k]);
      q = acc / (longint'(1) << FRAC_BITS);
      r.clip = 1'b0;
      if (q > OUT_MAX) begin
        q = OUT_MAX;
        r.clip = 1'b1;
      end else if (q < OUT_MIN) begin
        q = OUT_MIN;
        r.clip = 1'b1;
      end
      r.value = sample_t'(q);
      pending.push_back(r);
    endfunction

    function void check_output(sample_t got, logic got_clip);
      filt_result_t e;
      if (pending.size() == 0) begin
        note_fail($sformatf("unexpected output: filtered_out %0d clipped %0b", got, got_clip));
        return;
      end
      e = pending.pop_front();
      if (got !== e.value || got_clip !== e.clip) begin
        note_fail($sformatf("mismatch: filtered_out exp %0d got %0d, clipped exp %0b got %0b",
                            e.value, got, e.clip, got_clip));
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  sample_valid;
  logic                  sample_stall;
  sample_t               sample_in;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  sample_t               filtered_out;
  logic                  clipped;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fir_output_check chk;
  int send_pct = 0;
  int recv_pct = 0;
  int send_calm = 0;
  int recv_calm = 0;

  fir_filter_mono u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_in    (sample_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .filtered_out (filtered_out),
    .clipped      (clipped),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    if (recv_calm > 0) begin
      recv_calm <= recv_calm - 1;
      result_stall <= 1'b0;
    end else if ($urandom_range(0, 39) == 0) begin
      recv_calm <= $urandom_range(8, 50);
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) chk.check_output(filtered_out, clipped);
  end

  task automatic send_sample(sample_t s);
    if (send_calm > 0) begin
      send_calm--;
    end else if ($urandom_range(0, 39) == 0) begin
      send_calm = $urandom_range(8, 50);
    end else begin
      while ($urandom_range(0, 99) < send_pct) begin
        @(negedge clk);
        sample_valid <= 1'b0;
        @(posedge clk);
      end
    end
    @(negedge clk);
    sample_valid <= 1'b1;
    sample_in <= s;
    do @(posedge clk); while (!(sample_valid && !sample_stall));
    chk.take_sample(s);
  endtask

  // Holds the sender back until every queued output has been transferred.
  task automatic wait_drained();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (chk.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    chk.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_coef(int idx, coef_t c);
    write_reg(CFG_COEF_INDEX, CFG_DATA_W'(idx));
    write_reg(CFG_COEF_VALUE, CFG_DATA_W'(c));
  endtask

  task automatic load_table(table_kind_t kind);
    coef_t c;
    for (int k = 0; k < TAPS; k++) begin
      case (kind)
        TABLE_UNITY: c = (k == 0) ? COEF_HI : coef_t'(0);
        TABLE_MIN: c = COEF_LO;
        TABLE_MAX: c = COEF_HI;
        TABLE_MILD: c = coef_t'(int'($urandom_range(0, 4095)) - 2048);
        default: c = coef_t'($urandom());
      endcase
      load_coef(k, c);
    end
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_HI;
      1: return SAMPLE_LO;
      2, 3, 4: return sample_t'($urandom());
      default: return sample_t'(int'($urandom_range(0, 2047)) - 1024);
    endcase
  endfunction

  initial begin
    sample_t corner_samples[7];
    sample_t run_val;
    int n;
    int run_len;
    logic paused;
    chk = new();
    rst = 1'b1;
    sample_valid = 1'b0;
    sample_in = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    corner_samples = '{SAMPLE_HI, SAMPLE_LO, sample_t'(0), sample_t'(-1), sample_t'(1),
                       sample_t'(16'h5555), sample_t'(16'haaaa)};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // With the table still cleared from reset every output is zero.
    send_sample(SAMPLE_HI);
    send_sample(SAMPLE_LO);
    wait_drained();

    load_table(TABLE_UNITY);
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, CFG_DATA_W'(16'h1234));
    write_reg(CFG_COEF_INDEX, CFG_DATA_W'(3));
    foreach (corner_samples[k]) send_sample(corner_samples[k]);
    wait_drained();

    // A single product of two full-scale negative values already exceeds the positive limit.
    load_table(TABLE_MIN);
    repeat (8) send_sample(SAMPLE_LO);
    repeat (6) send_sample(SAMPLE_HI);

    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          load_table(TABLE_RANDOM);
          send_pct = 35;
          recv_pct = 66;
        end
        1: begin
          load_table(TABLE_MILD);
          send_pct = 66;
          recv_pct = 35;
        end
        default: begin
          load_table(TABLE_MAX);
          send_pct = 0;
          recv_pct = 0;
        end
      endcase
      n = 0;
      paused = 1'b0;
      while (n < PHASE_ITEMS) begin
        if (!paused && n >= PHASE_ITEMS / 2) begin
          paused = 1'b1;
          wait_drained();
          load_coef($urandom_range(0, TAPS - 1), coef_t'($urandom()));
          write_reg(CFG_COEF_INDEX, CFG_DATA_W'($urandom_range(0, TAPS - 1)));
        end
        if ($urandom_range(0, 39) == 0) begin
          run_val = $urandom_range(0, 1) ? SAMPLE_HI : SAMPLE_LO;
          run_len = $urandom_range(TAPS, TAPS + 8);
          repeat (run_len) send_sample(run_val);
          n += run_len;
        end else begin
          send_sample(random_sample());
          n++;
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (chk.fails == 0) begin
      $display("fir_filter_mono regression: pass");
    end else begin
      $display("fir_filter_mono regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("fir_filter_mono regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
design/fir_pkg.sv
design/fir_taps.sv
design/fir_mac.sv
design/fir_filter_mono.sv
design/fir_chk.sv
tb/sv/tb_fir_filter_mono.sv
